[hw/rtl/esae_pkg.sv]
// Shared constants, types and register codes for the encoder speed and acceleration estimator.
// Used by every module of the block; depends on nothing.
package esae_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int P_TAP = HISTORY_DEPTH / 2 - 1;
  localparam int Q_TAP = HISTORY_DEPTH - 1;

  localparam int CNT_W = 32;
  localparam int DELTA_W = CNT_W + 1;
  localparam int SUM_W = DELTA_W + 3;
  localparam int MAG_W = SUM_W - 1;
  localparam int GAIN_W = 48;
  localparam int CHUNK_W = 16;
  localparam int NUM_CHUNKS = GAIN_W / CHUNK_W;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int FRAC_SHIFT = 16;
  localparam int RND_W = PROD_W - FRAC_SHIFT;
  localparam int OUT_W = 48;

  localparam int KMH_LIM_W = 62;
  localparam int KMH_DEN = 5;
  localparam int REM_W = 3;
  localparam int DIGIT_W = 8;
  localparam int DIV_STEPS = 9;
  localparam int DIV_W = DIGIT_W * DIV_STEPS;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN = 2'd3;

  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef enum logic [1:0] {
    SEL_POS,
    SEL_SPD,
    SEL_ACC,
    SEL_KMH
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUMS,
    ST_MAG,
    ST_MSTART,
    ST_MWAIT,
    ST_ROUND,
    ST_SAT,
    ST_KWAIT,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/encoder_speed_accel_estimator_top.sv]
// Top level of the encoder speed and acceleration estimator.
// Depends on esae_pkg, esae_delta_cell, esae_mul and esae_div5.
//
// Channel  Dir  Handshake                  Payload
// sample   in   sample_valid/sample_ready  count_value, dir_forward
// result   out  result_valid/result_ready  position_m, speed_mps, speed_kmh, accel_mps2,
//                                          moving_forward, going_backwards
// cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A sample request is taken in the idle state and its result is loaded into the result register
// in the output step; no new request is taken before then. The time a sample takes is set
// by the shared 35x16 multiplier, which makes three passes of three partial products, and
// by the byte-wide divide by five behind the km/h result.
// Reset clears the history cells, the configuration registers, the state and the result valid flag.
// A stalled result holds the block only in its last step; the next request is still
// taken while the loaded result waits.
module encoder_speed_accel_estimator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic [esae_pkg::CNT_W-1:0]      count_value,
  input  logic                            dir_forward,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [esae_pkg::OUT_W-1:0] position_m,
  output logic signed [esae_pkg::OUT_W-1:0] speed_mps,
  output logic signed [esae_pkg::OUT_W-1:0] speed_kmh,
  output logic signed [esae_pkg::OUT_W-1:0] accel_mps2,
  output logic                            moving_forward,
  output logic                            going_backwards,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esae_pkg::CFG_DATA_W-1:0] cfg_data
);
  import esae_pkg::*;

  localparam logic [RND_W-1:0] NEG_LIM = RND_W'(1) << (OUT_W - 1);
  localparam logic [RND_W-1:0] POS_LIM = NEG_LIM - RND_W'(1);
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};

  state_t state, state_next;
  res_sel_t sel;

  logic [CNT_W-1:0]  start_count;
  logic [CNT_W-1:0]  dist_per_count;
  logic [GAIN_W-1:0] speed_gain;
  logic [GAIN_W-1:0] accel_gain;

  logic shift, ld_mag, mul_start, div_start, ld_rnd, ld_slot, ld_out;

  delta_t d_r, d_next;
  logic   dir_r, back_r;
  delta_t chain [HISTORY_DEPTH];

  logic signed [SUM_W-1:0] d_x, p_x, q_x, s_sum, a_sum, s_r, a_r;
  logic [MAG_W-1:0] mag_pos, mag_spd, mag_acc;
  logic neg_pos, neg_spd, neg_acc, neg_cur;

  logic [MAG_W-1:0]  mul_mag;
  logic [GAIN_W-1:0] mul_gain;
  logic              mul_done;
  logic [PROD_W-1:0] product;

  logic [DIV_W-1:0] spd_ext, dividend, quotient;
  logic             div_done;

  logic [PROD_W-1:0] rnd_src;
  logic [RND_W-1:0]  rnd_r, lim;
  logic [OUT_W-1:0]  low, sat_val;
  logic [OUT_W-1:0]  slot_pos, slot_spd, slot_acc, slot_kmh;

  function automatic logic signed [SUM_W-1:0] sx(delta_t v);
    return {{(SUM_W - DELTA_W){v[DELTA_W-1]}}, v};
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] n;
    n = v[SUM_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_count <= '0;
      dist_per_count <= '0;
      speed_gain <= '0;
      accel_gain <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_COUNT:    start_count <= cfg_data[CNT_W-1:0];
        CFG_DIST_PER_COUNT: dist_per_count <= cfg_data[CNT_W-1:0];
        CFG_SPEED_GAIN:     speed_gain <= cfg_data[GAIN_W-1:0];
        CFG_ACCEL_GAIN:     accel_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // History line: cell zero holds the newest delta.
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      esae_delta_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d_in (d_r),
        .d_out(chain[g])
      );
    end else begin : g_body
      esae_delta_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d_in (chain[g-1]),
        .d_out(chain[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sample_ready = 1'b0;
    shift = 1'b0;
    ld_mag = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    ld_rnd = 1'b0;
    ld_slot = 1'b0;
    ld_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = ST_SUMS;
        end
      end
      ST_SUMS: begin
        shift = 1'b1;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        ld_mag = 1'b1;
        state_next = ST_MSTART;
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_next = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ld_rnd = 1'b1;
        div_start = (sel == SEL_SPD);
        state_next = ST_SAT;
      end
      ST_SAT: begin
        ld_slot = 1'b1;
        case (sel)
          SEL_POS, SEL_SPD: state_next = ST_MSTART;
          SEL_ACC:          state_next = ST_KWAIT;
          default:          state_next = ST_OUT;
        endcase
      end
      ST_KWAIT: begin
        if (div_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (!result_valid || result_ready) begin
          ld_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign d_next = $signed({1'b0, count_value}) - $signed({1'b0, start_count});
  assign d_x = sx(d_r);
  assign p_x = sx(chain[P_TAP]);
  assign q_x = sx(chain[Q_TAP]);
  assign s_sum = (d_x <<< 1) + d_x - (p_x <<< 2) + q_x;
  assign a_sum = d_x - (p_x <<< 1) + q_x;

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      d_r <= d_next;
      dir_r <= dir_forward;
    end
    if (shift) begin
      s_r <= s_sum;
      a_r <= a_sum;
      back_r <= (d_r < chain[0]);
    end
    if (ld_mag) begin
      mag_pos <= mag_of(d_x);
      mag_spd <= mag_of(s_r);
      mag_acc <= mag_of(a_r);
      neg_pos <= d_x[SUM_W-1];
      neg_spd <= s_r[SUM_W-1];
      neg_acc <= a_r[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= SEL_POS;
    end else if (ld_mag) begin
      sel <= SEL_POS;
    end else if (ld_slot) begin
      case (sel)
        SEL_POS: sel <= SEL_SPD;
        SEL_SPD: sel <= SEL_ACC;
        SEL_ACC: sel <= SEL_KMH;
        default: sel <= SEL_POS;
      endcase
    end
  end

  always_comb begin
    case (sel)
      SEL_POS: begin
        mul_mag = mag_pos;
        mul_gain = GAIN_W'(dist_per_count);
        neg_cur = neg_pos;
      end
      SEL_SPD: begin
        mul_mag = mag_spd;
        mul_gain = speed_gain;
        neg_cur = neg_spd;
      end
      SEL_ACC: begin
        mul_mag = mag_acc;
        mul_gain = accel_gain;
        neg_cur = neg_acc;
      end
      default: begin
        mul_mag = '0;
        mul_gain = '0;
        neg_cur = neg_spd;
      end
    endcase
  end

  esae_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mag    (mul_mag),
    .gain   (mul_gain),
    .done   (mul_done),
    .product(product)
  );

  // The km/h product is the speed product times 18/5; a product of 2^62 or more saturates
  // anyway, so it is replaced by an all-ones dividend.
  assign spd_ext = DIV_W'(product[KMH_LIM_W-1:0]);
  assign dividend = (product[PROD_W-1:KMH_LIM_W] == '0) ?
                    (spd_ext << 4) + (spd_ext << 1) : '1;

  esae_div5 u_div5 (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .done    (div_done),
    .quotient(quotient)
  );

  assign rnd_src = (sel == SEL_KMH) ? PROD_W'(quotient) : product;

  always_ff @(posedge clk) begin
    if (ld_rnd) begin
      rnd_r <= RND_W'(rnd_src >> FRAC_SHIFT) + RND_W'(rnd_src[FRAC_SHIFT-1]);
    end
  end

  always_comb begin
    lim = neg_cur ? NEG_LIM : POS_LIM;
    low = rnd_r[OUT_W-1:0];
    if (rnd_r > lim) begin
      sat_val = neg_cur ? OUT_MIN : OUT_MAX;
    end else begin
      sat_val = neg_cur ? -low : low;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_slot) begin
      case (sel)
        SEL_POS: slot_pos <= sat_val;
        SEL_SPD: slot_spd <= sat_val;
        SEL_ACC: slot_acc <= sat_val;
        default: slot_kmh <= sat_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ld_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      position_m <= slot_pos;
      speed_mps <= slot_spd;
      speed_kmh <= slot_kmh;
      accel_mps2 <= slot_acc;
      moving_forward <= dir_r;
      going_backwards <= back_r;
    end
  end

endmodule

[hw/rtl/esae_delta_cell.sv]
// One cell of the delta history line: holds one past delta and passes it to the next cell.
// Depends on esae_pkg.
module esae_delta_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  esae_pkg::delta_t d_in,
  output esae_pkg::delta_t d_out
);
  import esae_pkg::*;

  delta_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= d_in;
    end
  end

  assign d_out = value;

endmodule

[hw/rtl/esae_mul.sv]
// Sequential magnitude by gain multiplier built on one 35 by 16 bit multiplier.
// Gain chunks are taken most significant first and accumulated; depends on esae_pkg.
module esae_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [esae_pkg::MAG_W-1:0]  mag,
  input  logic [esae_pkg::GAIN_W-1:0] gain,
  output logic                        done,
  output logic [esae_pkg::PROD_W-1:0] product
);
  import esae_pkg::*;

  localparam int STEP_W = $clog2(NUM_CHUNKS + 1);
  localparam int PP_W = MAG_W + CHUNK_W;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CHUNK_W-1:0] chunk;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] acc;

  always_comb begin
    chunk = '0;
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (step == STEP_W'(NUM_CHUNKS - 1 - k)) begin
        chunk = gain[k*CHUNK_W +: CHUNK_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      if (step == STEP_W'(NUM_CHUNKS)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (busy) begin
      if (step != '0) begin
        acc <= (acc << CHUNK_W) + PROD_W'(pp);
      end
      if (step != STEP_W'(NUM_CHUNKS)) begin
        pp <= PP_W'(mag) * PP_W'(chunk);
      end
    end
  end

  assign product = acc;

endmodule

[hw/rtl/esae_div5.sv]
// Divide by five, one byte of the dividend per cycle, most significant byte first.
// Used for the km/h result; depends on esae_pkg.
module esae_div5 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [esae_pkg::DIV_W-1:0] dividend,
  output logic                       done,
  output logic [esae_pkg::DIV_W-1:0] quotient
);
  import esae_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [DIV_W-1:0]   work;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_next;
  logic [REM_W:0]     trial;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] qdigit;

  always_comb begin
    digit = work[DIV_W-1 -: DIGIT_W];
    rem_next = rem;
    qdigit = '0;
    trial = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      trial = {rem_next, digit[i]};
      if (trial >= (REM_W + 1)'(KMH_DEN)) begin
        qdigit[i] = 1'b1;
        rem_next = REM_W'(trial - (REM_W + 1)'(KMH_DEN));
      end else begin
        rem_next = trial[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem <= '0;
    end else if (busy) begin
      work <= {work[DIV_W-DIGIT_W-1:0], qdigit};
      rem <= rem_next;
    end
  end

  assign quotient = work;

endmodule

[hw/rtl/esae_checker.sv]
// Port-level checks for the encoder speed and acceleration estimator, and the bind that
// attaches them to the top level. Depends on esae_pkg.
module esae_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            sample_valid,
  input logic                            sample_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic signed [esae_pkg::OUT_W-1:0] position_m,
  input logic signed [esae_pkg::OUT_W-1:0] speed_mps,
  input logic signed [esae_pkg::OUT_W-1:0] speed_kmh,
  input logic signed [esae_pkg::OUT_W-1:0] accel_mps2,
  input logic                            moving_forward,
  input logic                            going_backwards
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("Result request dropped before it was taken.");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(position_m) && $stable(speed_mps) &&
      $stable(speed_kmh) && $stable(accel_mps2) && $stable(moving_forward) &&
      $stable(going_backwards))
    else $error("Result payload changed while stalled.");

  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("A second sample was offered entry while one is in work.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!sample_ready))
    else $error("A result appeared while the block was idle.");

endmodule

bind encoder_speed_accel_estimator_top esae_checker u_esae_checker (.*);
